/* rtl/sma_pkg.sv */
// Shared constants, codes and types of the stack machine ALU.
`default_nettype none

package sma_pkg;

    // Stack and register file sizes.
    localparam int STACK_DEPTH = 64;
    localparam int REG_COUNT   = 8;

    // Widths; the address, depth and register index widths are derived.
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int REG_AW      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int OUT_DEPTH_W = 7;

    typedef logic [WORD_W-1:0] t_word;

    // Command codes of the input request.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_POP  = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_DIV  = 3'd5,
        CMD_SQRT = 3'd6,
        CMD_POPR = 3'd7
    } t_cmd;

    // Status codes of the result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_NEGROOT = 3'd4
    } t_status;

    // Operations of the shared arithmetic unit.
    typedef enum logic [2:0] {
        ALU_ADD  = 3'd0,
        ALU_SUB  = 3'd1,
        ALU_MUL  = 3'd2,
        ALU_DIV  = 3'd3,
        ALU_SQRT = 3'd4
    } t_alu_op;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic    start;
        t_alu_op op;
        t_word   a;
        t_word   b;
    } t_alu_req;

    // Response of the arithmetic unit.
    typedef struct packed {
        logic  done;
        t_word result;
    } t_alu_rsp;

endpackage

`default_nettype wire

/* rtl/sma_stack_ram.sv */
// Operand stack storage: one write port and one registered read port.
`default_nettype none

module sma_stack_ram
    import sma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_word             i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_word             o_rd_data
);

    t_word r_mem [STACK_DEPTH];
    t_word r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/sma_alu.sv */
// Shared arithmetic unit: registered add, subtract and multiply, iterative divide and root.
`default_nettype none

module sma_alu
    import sma_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam int STEP_W = WORD_W + 2;
    localparam int HALF_W = WORD_W / 2;
    localparam int CNT_W  = $clog2(WORD_W);

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    t_word             r_rem;
    t_word             r_q;
    t_word             r_div;
    logic [HALF_W-1:0] r_root;
    t_word             r_res;

    logic [STEP_W-1:0] sub_a;
    logic [STEP_W-1:0] sub_b;
    logic [STEP_W-1:0] diff;
    logic              take;
    t_word             mag_a;
    t_word             mag_b;

    // Shared trial subtractor: divisor step or root digit step.
    always_comb begin
        if (r_op == ALU_SQRT) begin
            sub_a = {r_rem, r_q[WORD_W-1 -: 2]};
            sub_b = {{(STEP_W-HALF_W-2){1'b0}}, r_root, 2'b01};
        end else begin
            sub_a = {1'b0, r_rem, r_q[WORD_W-1]};
            sub_b = {2'b00, r_div};
        end
        diff = sub_a - sub_b;
        take = !diff[STEP_W-1];
    end

    // Operand magnitudes for the divider.
    assign mag_a = i_req.a[WORD_W-1] ? (t_word'(0) - i_req.a) : i_req.a;
    assign mag_b = i_req.b[WORD_W-1] ? (t_word'(0) - i_req.b) : i_req.b;

    // Control: busy flag, step counter and completion strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_ADD;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op <= i_req.op;
                unique case (i_req.op)
                    ALU_DIV: begin
                        r_busy <= 1'b1;
                        r_cnt  <= CNT_W'(WORD_W - 1);
                    end
                    ALU_SQRT: begin
                        r_busy <= 1'b1;
                        r_cnt  <= CNT_W'(HALF_W - 1);
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand load and one shift-subtract step per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            unique case (i_req.op)
                ALU_ADD: r_res <= i_req.a + i_req.b;
                ALU_SUB: r_res <= i_req.a - i_req.b;
                ALU_MUL: r_res <= t_word'(i_req.a * i_req.b);
                ALU_DIV: begin
                    r_rem <= '0;
                    r_q   <= mag_a;
                    r_div <= mag_b;
                    r_neg <= i_req.a[WORD_W-1] ^ i_req.b[WORD_W-1];
                end
                ALU_SQRT: begin
                    r_rem  <= '0;
                    r_q    <= i_req.a;
                    r_root <= '0;
                end
                default: r_res <= '0;
            endcase
        end else if (r_busy) begin
            if (r_op == ALU_SQRT) begin
                r_q <= {r_q[WORD_W-3:0], 2'b00};
                if (take) begin
                    r_rem  <= diff[WORD_W-1:0];
                    r_root <= {r_root[HALF_W-2:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[WORD_W-3:0], r_q[WORD_W-1 -: 2]};
                    r_root <= {r_root[HALF_W-2:0], 1'b0};
                end
            end else begin
                if (take) begin
                    r_rem <= diff[WORD_W-1:0];
                    r_q   <= {r_q[WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[WORD_W-2:0], r_q[WORD_W-1]};
                    r_q   <= {r_q[WORD_W-2:0], 1'b0};
                end
            end
        end
    end

    // Result selection; the quotient takes its sign here.
    always_comb begin
        o_rsp.done = r_done;
        unique case (r_op)
            ALU_DIV:  o_rsp.result = r_neg ? (t_word'(0) - r_q) : r_q;
            ALU_SQRT: o_rsp.result = {{(WORD_W-HALF_W){1'b0}}, r_root};
            default:  o_rsp.result = r_res;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/stack_machine_alu_unit.sv */
// Top level of the stack machine ALU: command sequencer, stack pointer and register file.
//
// Usage: drive i_command, i_operand and i_reg_index and raise start; the request is
// taken at a rising edge where start is high and busy is low. Each request yields
// exactly one result, shown on o_top_value, o_status and o_stack_depth for one cycle
// while o_valid is high. The receiver cannot stall; it must take the result then.
// Push, pop, pop to register and every error case finish without the shared unit;
// add, subtract and multiply use its registered result; square root takes 16 root
// digit steps of the shared unit and divide 32 quotient bit steps.
// A new request can be accepted in the cycle o_valid is high. Each request reads the
// top two stack entries, in S_RD_TOP and S_RD_SEC, through the single read port of
// the stack memory.
// Reset (synchronous, active low) empties the stack, clears the register file and
// drops busy and o_valid; the stack memory itself is not cleared and needs no sweep.
`default_nettype none

module stack_machine_alu_unit
    import sma_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [WORD_W-1:0]  i_operand,
    input  logic [2:0]                i_reg_index,
    output logic                      o_valid,
    output logic signed [WORD_W-1:0]  o_top_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic [OUT_DEPTH_W-1:0]    o_stack_depth
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_RD_TOP   = 5'b00010,
        S_RD_SEC   = 5'b00100,
        S_DECIDE   = 5'b01000,
        S_WAIT_ALU = 5'b10000
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    t_word                r_operand;
    logic [2:0]           r_ridx;
    logic [DEPTH_W-1:0]   r_depth;
    t_word                r_b;
    t_word                r_regs [REG_COUNT];
    logic                 r_valid;
    t_word                r_top;
    t_status              r_status;
    logic [DEPTH_W-1:0]   r_out_depth;

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    t_word                rd_data;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    t_word                wr_data;
    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;

    logic                 accept;
    logic                 d_zero;
    logic                 d_lt2;
    logic                 d_full;
    logic                 b_zero;
    logic                 b_neg;
    logic                 is_bin;
    logic                 push_ok;
    logic                 pop_ok;
    logic                 alu_go;
    logic [ADDR_W-1:0]    top_addr;
    logic [ADDR_W-1:0]    sec_addr;
    t_status              n_status;
    logic [DEPTH_W-1:0]   n_depth;
    t_word                n_value;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Stack pointer decode and checks on the fetched top entry.
    assign d_zero   = (r_depth == '0);
    assign d_lt2    = (r_depth < DEPTH_W'(2));
    assign d_full   = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign b_zero   = (r_b == '0);
    assign b_neg    = r_b[WORD_W-1];
    assign top_addr = ADDR_W'(r_depth - DEPTH_W'(1));
    assign sec_addr = ADDR_W'(r_depth - DEPTH_W'(2));
    assign is_bin   = (r_cmd == CMD_ADD) || (r_cmd == CMD_SUB) ||
                      (r_cmd == CMD_MUL) || (r_cmd == CMD_DIV);
    assign push_ok  = (r_cmd == CMD_PUSH) && !d_full;
    assign pop_ok   = ((r_cmd == CMD_POP) || (r_cmd == CMD_POPR)) && !d_zero;
    assign alu_go   = (r_state == S_DECIDE) &&
                      (((r_cmd == CMD_SQRT) && !d_zero && !b_neg) ||
                       (is_bin && !d_lt2 && !((r_cmd == CMD_DIV) && b_zero)));

    // Status, new depth and reported value for requests that finish without the unit.
    always_comb begin
        n_status = ST_OK;
        unique case (r_cmd)
            CMD_PUSH: begin
                if (d_full) begin
                    n_status = ST_OVER;
                end
            end
            CMD_POP, CMD_POPR: begin
                if (d_zero) begin
                    n_status = ST_UNDER;
                end
            end
            CMD_SQRT: begin
                priority if (d_zero) begin
                    n_status = ST_UNDER;
                end else if (b_neg) begin
                    n_status = ST_NEGROOT;
                end else begin
                    n_status = ST_OK;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                priority if (d_lt2) begin
                    n_status = ST_UNDER;
                end else if ((r_cmd == CMD_DIV) && b_zero) begin
                    n_status = ST_DIVZERO;
                end else begin
                    n_status = ST_OK;
                end
            end
        endcase
        priority if (push_ok) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if (pop_ok) begin
            n_depth = r_depth - DEPTH_W'(1);
        end else begin
            n_depth = r_depth;
        end
        n_value = push_ok ? r_operand : r_b;
    end

    // Memory port and arithmetic unit request.
    always_comb begin
        rd_en   = (r_state == S_RD_TOP) || (r_state == S_RD_SEC);
        rd_addr = (r_state == S_RD_TOP) ? top_addr : sec_addr;
        wr_en   = ((r_state == S_DECIDE) && push_ok) ||
                  ((r_state == S_WAIT_ALU) && alu_rsp.done);
        if (r_state == S_DECIDE) begin
            wr_addr = ADDR_W'(r_depth);
            wr_data = r_operand;
        end else begin
            wr_addr = (r_cmd == CMD_SQRT) ? top_addr : sec_addr;
            wr_data = alu_rsp.result;
        end
        alu_req.start = alu_go;
        alu_req.a     = rd_data;
        alu_req.b     = r_b;
        unique case (r_cmd)
            CMD_ADD:  alu_req.op = ALU_ADD;
            CMD_SUB:  alu_req.op = ALU_SUB;
            CMD_MUL:  alu_req.op = ALU_MUL;
            CMD_DIV:  alu_req.op = ALU_DIV;
            CMD_SQRT: begin
                alu_req.op = ALU_SQRT;
                alu_req.a  = r_b;
            end
            CMD_PUSH, CMD_POP, CMD_POPR: alu_req.op = ALU_ADD;
        endcase
    end

    sma_stack_ram u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sma_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // Sequencer: fetch top two entries, decide, wait for the unit, report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RD_TOP;
                    end
                end
                S_RD_TOP: begin
                    r_state <= S_RD_SEC;
                end
                S_RD_SEC: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (alu_go) begin
                        r_state <= S_WAIT_ALU;
                    end else begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                        r_depth <= n_depth;
                    end
                end
                S_WAIT_ALU: begin
                    if (alu_rsp.done) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                        if (r_cmd != CMD_SQRT) begin
                            r_depth <= r_depth - DEPTH_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    // Request capture, fetched top entry and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= t_cmd'(i_command);
            r_operand <= t_word'(i_operand);
            r_ridx    <= i_reg_index;
        end
        if (r_state == S_RD_SEC) begin
            r_b <= d_zero ? '0 : rd_data;
        end
        if ((r_state == S_DECIDE) && !alu_go) begin
            r_top       <= n_value;
            r_status    <= n_status;
            r_out_depth <= n_depth;
        end else if ((r_state == S_WAIT_ALU) && alu_rsp.done) begin
            r_top       <= alu_rsp.result;
            r_status    <= ST_OK;
            r_out_depth <= (r_cmd == CMD_SQRT) ? r_depth : (r_depth - DEPTH_W'(1));
        end
    end

    // Register file written by pop to register; an index out of range writes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else if ((r_state == S_DECIDE) && pop_ok && (r_cmd == CMD_POPR) &&
                     (int'(r_ridx) < REG_COUNT)) begin
            r_regs[REG_AW'(r_ridx)] <= r_b;
        end
    end

    assign o_valid       = r_valid;
    assign o_top_value   = r_top;
    assign o_status      = r_status;
    assign o_stack_depth = OUT_DEPTH_W'(r_out_depth);

`ifndef SYNTHESIS
    // A result is never followed by another in the next cycle.
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back results");

    // No result appears in the cycle after a request is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_valid)
        else $error("result too early after request");

    // The block leaves busy only together with a result.
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("busy dropped without a result");

    // An overflow is only reported on a full stack.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_status == ST_OVER)) |-> (r_out_depth == DEPTH_W'(STACK_DEPTH)))
        else $error("overflow with a stack that is not full");

    // The stack pointer never passes the stack size.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack pointer beyond the stack size");
`endif

endmodule

`default_nettype wire
